>>> sv/btf_pkg.sv
// ----------------------------------------------------------------------------
// BER-TLV tag finder package
// Shared types and constants for the tag finder modules.
// ----------------------------------------------------------------------------
package btf_pkg;

  localparam int unsigned MaxTagBytes    = 2;  // 1..2
  localparam int unsigned MaxLengthBytes = 2;  // 1..2

  localparam logic [4:0] TagMoreMask  = 5'h1F;
  localparam logic [6:0] LenCountMask = 7'h7F;

  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_SKIP      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_TOO_BIG   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MESSAGE_LENGTH = 2'd0,
    REG_TARGET_TAG     = 2'd1,
    REG_VALUE_CAPACITY = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] message_length;
    logic [15:0] target_tag;
    logic [15:0] value_capacity;
  } cfg_t;

  typedef struct packed {
    logic        has_result;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        status_valid;
    status_e     status;
    logic [15:0] value_length;
  } result_t;

endpackage

>>> sv/btf_parser.sv
// ----------------------------------------------------------------------------
// BER-TLV tag finder parser
// Parse state and the one-byte step: tag, length, skip and value phases.
// ----------------------------------------------------------------------------
module btf_parser import btf_pkg::*; #(
  parameter int unsigned TagBytesMax = MaxTagBytes,
  parameter int unsigned LenBytesMax = MaxLengthBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] tag_q, tag_d;
  logic [1:0]  tcnt_q, tcnt_d;
  logic [1:0]  lleft_q, lleft_d;
  logic [15:0] vlen_q, vlen_d;
  logic [15:0] vleft_q, vleft_d;
  logic        match_q, match_d;
  logic        fin_q, fin_d;

  logic [15:0] total;
  logic [16:0] pos;
  logic [16:0] bytes_after;
  logic        at_end;
  logic        len_done;
  result_t     res;

  assign total       = (cfg_i.message_length == 16'd0) ? 16'd1 : cfg_i.message_length;
  assign pos         = {1'b0, offset_q} + 17'd1;
  assign bytes_after = ({1'b0, total} > pos) ? ({1'b0, total} - pos) : 17'd0;
  assign at_end      = (bytes_after == 17'd0);

  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    tag_d    = tag_q;
    tcnt_d   = tcnt_q;
    lleft_d  = lleft_q;
    vlen_d   = vlen_q;
    vleft_d  = vleft_q;
    match_d  = match_q;
    fin_d    = fin_q;
    len_done = 1'b0;
    res      = '0;

    if (!fin_q) begin
      case (phase_q)
        PH_TAG_FIRST: begin
          tag_d   = {8'd0, byte_i};
          tcnt_d  = 2'd1;
          phase_d = ((byte_i[4:0] & TagMoreMask) == TagMoreMask) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          if (tcnt_q >= 2'(TagBytesMax)) begin
            res.status_valid = 1'b1;
            res.status       = ST_MALFORMED;
            fin_d            = 1'b1;
          end else begin
            tcnt_d = tcnt_q + 2'd1;
            tag_d  = {tag_q[7:0], byte_i};
            if (!byte_i[7]) begin
              phase_d = PH_LEN_FIRST;
            end
          end
        end
        PH_LEN_FIRST: begin
          if (byte_i[7]) begin
            if ((byte_i[6:0] & LenCountMask) > 7'(LenBytesMax)) begin
              res.status_valid = 1'b1;
              res.status       = ST_MALFORMED;
              fin_d            = 1'b1;
            end else if (byte_i[6:0] == 7'd0) begin
              vlen_d   = 16'd0;
              len_done = 1'b1;
            end else begin
              vlen_d  = 16'd0;
              lleft_d = byte_i[1:0];
              phase_d = PH_LEN_MORE;
            end
          end else begin
            vlen_d   = {8'd0, byte_i};
            len_done = 1'b1;
          end
        end
        PH_LEN_MORE: begin
          vlen_d  = {vlen_q[7:0], byte_i};
          lleft_d = lleft_q - 2'd1;
          if (lleft_d == 2'd0) begin
            len_done = 1'b1;
          end
        end
        PH_SKIP: begin
          vleft_d = vleft_q - 16'd1;
          if (vleft_d == 16'd0) begin
            phase_d = PH_TAG_FIRST;
          end
        end
        PH_VALUE: begin
          res.byte_valid = 1'b1;
          res.out_byte   = byte_i;
          vleft_d        = vleft_q - 16'd1;
          if (vleft_d == 16'd0) begin
            res.status_valid = 1'b1;
            res.status       = ST_FOUND;
            res.value_length = vlen_q;
            fin_d            = 1'b1;
          end
        end
        default: begin
          res.status_valid = 1'b1;
          res.status       = ST_MALFORMED;
          fin_d            = 1'b1;
        end
      endcase
    end

    // Length field complete: check overrun, then match, capacity and skip.
    if (len_done) begin
      if ({1'b0, vlen_d} > bytes_after) begin
        res.status_valid = 1'b1;
        res.status       = ST_MALFORMED;
        fin_d            = 1'b1;
      end else begin
        match_d = (tag_d == cfg_i.target_tag);
        if (match_d) begin
          if (vlen_d > cfg_i.value_capacity) begin
            res.status_valid = 1'b1;
            res.status       = ST_TOO_BIG;
            res.value_length = vlen_d;
            fin_d            = 1'b1;
          end else if (vlen_d == 16'd0) begin
            res.status_valid = 1'b1;
            res.status       = ST_FOUND;
            fin_d            = 1'b1;
          end else begin
            vleft_d = vlen_d;
            phase_d = PH_VALUE;
          end
        end else if (vlen_d == 16'd0) begin
          phase_d = PH_TAG_FIRST;
        end else begin
          vleft_d = vlen_d;
          phase_d = PH_SKIP;
        end
      end
    end

    // Last byte of the message: close out and rearm for the next one.
    if (at_end) begin
      if (!fin_d) begin
        res.status_valid = 1'b1;
        res.status       = (phase_d == PH_TAG_FIRST) ? ST_NOT_FOUND : ST_MALFORMED;
        res.value_length = 16'd0;
      end
      phase_d  = PH_TAG_FIRST;
      offset_d = 16'd0;
      tag_d    = 16'd0;
      tcnt_d   = 2'd0;
      lleft_d  = 2'd0;
      vlen_d   = 16'd0;
      vleft_d  = 16'd0;
      match_d  = 1'b0;
      fin_d    = 1'b0;
    end else begin
      offset_d = offset_q + 16'd1;
    end

    res.has_result = res.byte_valid | res.status_valid;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG_FIRST;
      offset_q <= '0;
      tag_q    <= '0;
      tcnt_q   <= '0;
      lleft_q  <= '0;
      vlen_q   <= '0;
      vleft_q  <= '0;
      match_q  <= 1'b0;
      fin_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      tag_q    <= tag_d;
      tcnt_q   <= tcnt_d;
      lleft_q  <= lleft_d;
      vlen_q   <= vlen_d;
      vleft_q  <= vleft_d;
      match_q  <= match_d;
      fin_q    <= fin_d;
    end
  end

endmodule

>>> sv/btf_out_reg.sv
// ----------------------------------------------------------------------------
// BER-TLV tag finder result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module btf_out_reg import btf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> sv/ber_tlv_tag_finder.sv
// ----------------------------------------------------------------------------
// BER-TLV tag finder
// Scans a BER-TLV message byte by byte and streams out the value of the
// first element whose tag matches, followed by a status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, data_byte_i) takes one message
//   byte per request. Output channel (out_valid_o/out_ready_i) returns a
//   request only for bytes that produce something: a value byte of the
//   matching element, a status (found, too_big, not_found, malformed), or
//   both together on the last value byte.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) sets
//   message_length (0), target_tag (1) and value_capacity (2); it is always
//   ready. Write it only while the block is idle. Other indexes are dropped.
//   A byte is held in the input register, parsed, and its result is
//   loaded into the result register as the byte advances. Throughput:
//   one byte per cycle while the result register has room; the parse step
//   is a single pass through the parser logic between the two registers.
//   Reset: parse state clears to the start of a message, registers return
//   to message_length 1, target_tag 0, value_capacity 65535.
//   Stall: when the receiver holds out_ready_i low, the result register
//   holds; bytes producing no result still advance, and the input register
//   fills and then drops in_ready_o until the result is taken.
//   After a status the rest of the message is consumed silently, and the
//   next message starts on the byte after the last one.
// ----------------------------------------------------------------------------
module ber_tlv_tag_finder import btf_pkg::*; #(
  parameter int unsigned TagBytesMax = MaxTagBytes,
  parameter int unsigned LenBytesMax = MaxLengthBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        status_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] value_length_o
);

  cfg_t       cfg_q;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       in_fire;
  logic       out_free;
  result_t    step_res;
  result_t    out_res;

  // Configuration registers: always accept, ignore unknown indexes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.message_length <= 16'd1;
      cfg_q.target_tag     <= 16'd0;
      cfg_q.value_capacity <= 16'hFFFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MESSAGE_LENGTH: cfg_q.message_length <= cfg_data_i;
        REG_TARGET_TAG:     cfg_q.target_tag     <= cfg_data_i;
        REG_VALUE_CAPACITY: cfg_q.value_capacity <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: advance when the byte makes no result or the result
  // register has room.
  assign s1_adv     = s1_valid_q && (!step_res.has_result || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
    end
  end

  btf_parser #(
    .TagBytesMax (TagBytesMax),
    .LenBytesMax (LenBytesMax)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (s1_adv),
    .byte_i (s1_byte_q),
    .res_o  (step_res)
  );

  btf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_adv && step_res.has_result),
    .res_i   (step_res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign out_byte_o     = out_res.out_byte;
  assign byte_valid_o   = out_res.byte_valid;
  assign status_valid_o = out_res.status_valid;
  assign status_o       = out_res.status;
  assign value_length_o = out_res.value_length;

endmodule

>>> test/ber_tlv_tag_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BER-TLV tag finder testbench
// Feeds the tag finder short directed messages and then randomly built
// BER-TLV messages under changing register settings. A predictor in the
// bench parses every accepted byte and lines up the value bytes and statuses
// it owes; the monitor checks each returned request against them in order.
// ----------------------------------------------------------------------------
module ber_tlv_tag_finder_tb;
  import btf_pkg::*;

  localparam int unsigned DrainCycles = 8;     // result is registered after the input register
  localparam int unsigned ByteBudget  = 660;   // random bytes to queue, roughly

  // One returned request: a value byte, a status, or both together.
  typedef struct {
    logic [7:0]  data;
    logic        data_ok;
    logic        status_ok;
    status_e     code;
    logic [15:0] length;
  } tlv_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        status_valid_o;
  logic [1:0]  status_o;
  logic [15:0] value_length_o;

  ber_tlv_tag_finder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .status_valid_o (status_valid_o),
    .status_o       (status_o),
    .value_length_o (value_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  logic [7:0]  byte_feed_q[$];        // message bytes waiting for the driver
  tlv_result_t value_stream_q[$];     // value bytes and statuses still owed
  logic [7:0]  msg_buf[$];            // message under construction

  bit          gaps_on   = 1'b1;      // idle cycles between input requests
  bit          stalls_on = 1'b1;      // back-pressure on the result channel
  int unsigned hold_off   = 0;
  int unsigned stall_left = 0;

  int unsigned mismatch_count   = 0;
  int unsigned bytes_queued     = 0;
  int unsigned bytes_taken      = 0;
  int unsigned msg_count        = 0;
  int unsigned phase_count      = 0;
  int unsigned results_seen     = 0;
  int unsigned value_bytes_seen = 0;
  int unsigned status_seen[4]   = '{default: 0};

  // --------------------------------------------------------------------------
  // Parser predictor: register copies and parse state, reset values
  // --------------------------------------------------------------------------
  logic [15:0] cfg_msg_len = 16'd1;
  logic [15:0] cfg_tag     = 16'd0;
  logic [15:0] cfg_cap     = 16'hFFFF;

  phase_e      ph       = PH_TAG_FIRST;
  logic [15:0] pos      = '0;
  logic [15:0] tag_acc  = '0;
  logic [1:0]  tag_cnt  = '0;
  logic [1:0]  len_left = '0;
  logic [15:0] vlen     = '0;
  logic [15:0] vleft    = '0;
  logic        matched  = 1'b0;
  logic        halted   = 1'b0;     // status given, ignore rest of message
  tlv_result_t cur;

  // Bytes of the message that follow the current one; length 0 acts as 1.
  function automatic int unsigned bytes_left_after();
    int unsigned total;
    int unsigned here;
    total = (cfg_msg_len == 16'd0) ? 1 : cfg_msg_len;
    here  = pos + 1;
    return (total > here) ? total - here : 0;
  endfunction

  task automatic post_status(input status_e code, input logic [15:0] len);
    cur.status_ok = 1'b1;
    cur.code      = code;
    cur.length    = len;
    halted        = 1'b1;
  endtask

  task automatic restart_parse();
    ph       = PH_TAG_FIRST;
    pos      = '0;
    tag_acc  = '0;
    tag_cnt  = '0;
    len_left = '0;
    vlen     = '0;
    vleft    = '0;
    matched  = 1'b0;
    halted   = 1'b0;
  endtask

  // Length complete: reject an overrun, then stream, skip or finish.
  task automatic close_length();
    if (vlen > bytes_left_after()) begin
      post_status(ST_MALFORMED, '0);
    end else begin
      matched = (tag_acc == cfg_tag);
      if (matched) begin
        if (vlen > cfg_cap) begin
          post_status(ST_TOO_BIG, vlen);
        end else if (vlen == 16'd0) begin
          post_status(ST_FOUND, '0);
        end else begin
          vleft = vlen;
          ph    = PH_VALUE;
        end
      end else if (vlen == 16'd0) begin
        ph = PH_TAG_FIRST;
      end else begin
        vleft = vlen;
        ph    = PH_SKIP;
      end
    end
  endtask

  // Advance the parser by one accepted byte and queue what it owes.
  task automatic parse_tlv_byte(input logic [7:0] b);
    logic at_end;
    cur.data      = '0;
    cur.data_ok   = 1'b0;
    cur.status_ok = 1'b0;
    cur.code      = ST_FOUND;
    cur.length    = '0;
    at_end = (bytes_left_after() == 0);
    if (!halted) begin
      case (ph)
        PH_TAG_FIRST: begin
          tag_acc = {8'h00, b};
          tag_cnt = 2'd1;
          ph      = (b[4:0] == TagMoreMask) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          if (tag_cnt >= MaxTagBytes) begin
            post_status(ST_MALFORMED, '0);
          end else begin
            tag_cnt = tag_cnt + 2'd1;
            tag_acc = {tag_acc[7:0], b};
            if (!b[7]) ph = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          vlen = '0;
          if (b[7]) begin
            if ((b[6:0] & LenCountMask) > MaxLengthBytes) begin
              post_status(ST_MALFORMED, '0);
            end else if (b[6:0] == 7'd0) begin
              close_length();
            end else begin
              len_left = b[1:0];
              ph       = PH_LEN_MORE;
            end
          end else begin
            vlen = {8'h00, b};
            close_length();
          end
        end
        PH_LEN_MORE: begin
          vlen     = {vlen[7:0], b};
          len_left = len_left - 2'd1;
          if (len_left == 2'd0) close_length();
        end
        PH_SKIP: begin
          vleft = vleft - 16'd1;
          if (vleft == 16'd0) ph = PH_TAG_FIRST;
        end
        PH_VALUE: begin
          cur.data    = b;
          cur.data_ok = 1'b1;
          vleft       = vleft - 16'd1;
          if (vleft == 16'd0) post_status(ST_FOUND, vlen);
        end
        default: post_status(ST_MALFORMED, '0);
      endcase
    end
    // Message ends here: a clean boundary means no match, anything else was cut.
    if (at_end) begin
      if (!halted) post_status((ph == PH_TAG_FIRST) ? ST_NOT_FOUND : ST_MALFORMED, '0);
      restart_parse();
    end else begin
      pos = pos + 16'd1;
    end
    if (cur.data_ok || cur.status_ok) value_stream_q.push_back(cur);
  endtask

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic feed(input logic [7:0] b);
    byte_feed_q.push_back(b);
    bytes_queued++;
  endtask

  // Hold until every byte is taken and every result is back, then let the
  // pipeline drain bytes that owe nothing. Look again after the drain, since
  // the last byte may leave the queue on the same edge as the first look.
  task automatic wait_quiet();
    do begin
      while (byte_feed_q.size() != 0 || in_valid_i || value_stream_q.size() != 0)
        @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end while (byte_feed_q.size() != 0 || in_valid_i || value_stream_q.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MESSAGE_LENGTH: cfg_msg_len = val;
      REG_TARGET_TAG:     cfg_tag     = val;
      REG_VALUE_CAPACITY: cfg_cap     = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] len, input logic [15:0] tag,
                          input logic [15:0] cap);
    wait_quiet();
    write_reg(REG_MESSAGE_LENGTH, len);
    write_reg(REG_TARGET_TAG, tag);
    write_reg(REG_VALUE_CAPACITY, cap);
    phase_count++;
  endtask

  // Directed message: n bytes given first byte most significant.
  task automatic run_case(input logic [15:0] len, input logic [15:0] tag,
                          input logic [15:0] cap, input int n, input logic [63:0] bytes);
    set_regs(len, tag, cap);
    for (int i = n - 1; i >= 0; i--) feed(bytes[8*i +: 8]);
    msg_count++;
  endtask

  function automatic logic [15:0] short_tag();
    return {8'h00, 3'($urandom), 5'($urandom_range(0, 30))};
  endfunction

  function automatic logic [15:0] long_tag();
    return {3'($urandom), 5'h1F, 1'b0, 7'($urandom)};
  endfunction

  task automatic put_tag(input logic [15:0] tag, input bit two);
    if (two) msg_buf.push_back(tag[15:8]);
    msg_buf.push_back(tag[7:0]);
  endtask

  // One element: a tag that often is the sought one, a length in any of the
  // legal encodings, and random value bytes.
  task automatic add_element(input logic [15:0] tgt, input bit tgt_two);
    int unsigned r;
    int unsigned vl;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      put_tag(tgt, tgt_two);
    end else if (r < 45) begin
      // three tag bytes: one too many
      msg_buf.push_back({3'($urandom), 5'h1F});
      msg_buf.push_back({1'b1, 7'($urandom)});
      msg_buf.push_back(8'($urandom));
    end else if (r < 72) begin
      put_tag(short_tag(), 1'b0);
    end else begin
      put_tag(long_tag(), 1'b1);
    end
    r = $urandom_range(0, 99);
    if (r < 78)      vl = $urandom_range(0, 6);
    else if (r < 97) vl = $urandom_range(7, 30);
    else             vl = $urandom_range(100, 300);
    r = $urandom_range(0, 3);
    if (vl == 0 && r == 0) begin
      msg_buf.push_back(8'h80);
    end else if (vl < 128 && r < 2) begin
      msg_buf.push_back(8'(vl));
    end else if (vl < 256 && r == 2) begin
      msg_buf.push_back(8'h81);
      msg_buf.push_back(8'(vl));
    end else begin
      msg_buf.push_back(8'h82);
      msg_buf.push_back(8'(vl >> 8));
      msg_buf.push_back(8'(vl));
    end
    repeat (vl) msg_buf.push_back(8'($urandom));
  endtask

  // Well-formed elements, sometimes spoiled at the tail.
  task automatic build_message(input logic [15:0] tgt, input bit tgt_two);
    int unsigned r;
    msg_buf.delete();
    repeat ($urandom_range(1, 3)) add_element(tgt, tgt_two);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // long-form count beyond what the block accepts
      put_tag(short_tag(), 1'b0);
      msg_buf.push_back({1'b1, 7'($urandom_range(3, 127))});
    end else if (r < 12) begin
      // length larger than the rest of the message
      put_tag(tgt, tgt_two);
      if ($urandom_range(0, 1)) begin
        msg_buf.push_back(8'h82);
        msg_buf.push_back(8'hFF);
        msg_buf.push_back(8'hFF);
      end else begin
        msg_buf.push_back(8'h7F);
      end
    end else if (r < 18 && msg_buf.size() > 2) begin
      // cut inside the last element
      repeat ($urandom_range(1, 2)) void'(msg_buf.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued bytes, predict each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_tlv_byte(data_byte_i);
        bytes_taken++;
      end
      // Slot is free: idle out the gap or load the next byte.
      if (!in_valid_i || in_ready_o) begin
        if (hold_off > 0) begin
          hold_off--;
          in_valid_i <= 1'b0;
        end else if (byte_feed_q.size() != 0) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= byte_feed_q.pop_front();
          hold_off = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each returned request, throttle the result channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tlv_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (value_stream_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed: byte %h/%b status %0d/%b len %0d",
                                  out_byte_o, byte_valid_o, status_o, status_valid_o,
                                  value_length_o));
        end else begin
          want = value_stream_q.pop_front();
          if (byte_valid_o !== want.data_ok)
            flag_mismatch($sformatf("byte_valid %b, want %b", byte_valid_o, want.data_ok));
          if (out_byte_o !== want.data)
            flag_mismatch($sformatf("out_byte %h, want %h", out_byte_o, want.data));
          if (status_valid_o !== want.status_ok)
            flag_mismatch($sformatf("status_valid %b, want %b", status_valid_o,
                                    want.status_ok));
          if (status_o !== want.code)
            flag_mismatch($sformatf("status %0d, want %s", status_o, want.code.name()));
          if (value_length_o !== want.length)
            flag_mismatch($sformatf("value_length %0d, want %0d", value_length_o,
                                    want.length));
          if (want.data_ok) value_bytes_seen++;
          if (want.status_ok) status_seen[want.code]++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned r;
    logic [15:0] tgt;
    logic [15:0] cap;
    bit          tgt_two;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: one-byte message that stops inside the length field.
    feed(8'h00);
    msg_count++;
    // Two-byte tag found, capacity equal to the length.
    run_case(16'd6, 16'h9F21, 16'd3, 6, 64'h9F21_03AA_BBCC);
    // Match whose length exceeds capacity.
    run_case(16'd5, 16'h0005, 16'd2, 5, 64'h05_03_00_7F_80);
    // Empty match via long form with zero count, zero capacity.
    run_case(16'd2, 16'h0041, 16'd0, 2, 64'h41_80);
    // Third tag byte: tag too long.
    run_case(16'd3, 16'hFFFF, 16'hFFFF, 3, 64'h1F_81_82);
    // Long-form count of three: length field too long.
    run_case(16'd2, 16'h0000, 16'hFFFF, 2, 64'h01_83);
    // Length runs past the message end.
    run_case(16'd2, 16'h0000, 16'hFFFF, 2, 64'h01_05);
    // Clean end with no match.
    run_case(16'd2, 16'h0041, 16'hFFFF, 2, 64'h01_00);
    // Zero message length acts as one byte; message cut inside the tag.
    run_case(16'd0, 16'h0000, 16'hFFFF, 1, 64'hFF);
    // Two-byte long-form length streamed out.
    run_case(16'd6, 16'h0007, 16'hFFFF, 6, 64'h07_82_00_02_5A_C3);
    // Longest message, then shrink it mid-way so the next byte ends it.
    run_case(16'hFFFF, 16'h0002, 16'hFFFF, 3, 64'h01_02_AA);
    wait_quiet();
    write_reg(REG_MESSAGE_LENGTH, 16'd3);
    feed(8'h02);

    // Random messages, one register setting per message length.
    bytes_queued = 0;
    while (bytes_queued < ByteBudget) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        tgt     = short_tag();
        tgt_two = 1'b0;
      end else if (r < 90) begin
        tgt     = long_tag();
        tgt_two = 1'b1;
      end else begin
        tgt     = 16'($urandom);
        tgt_two = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 15)      cap = 16'd0;
      else if (r < 30) cap = 16'hFFFF;
      else if (r < 80) cap = 16'($urandom_range(0, 10));
      else             cap = 16'($urandom);
      build_message(tgt, tgt_two);
      set_regs(16'(msg_buf.size()), tgt, cap);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      foreach (msg_buf[i]) feed(msg_buf[i]);
      msg_count++;
      // Sometimes follow with a same-length message: a spoiled copy or noise.
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1)) begin
          msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom);
          foreach (msg_buf[i]) feed(msg_buf[i]);
        end else begin
          repeat (msg_buf.size()) feed(8'($urandom));
        end
        msg_count++;
      end
    end

    wait_quiet();
    $display("Covered %0d messages (%0d bytes) over %0d register settings.",
             msg_count, bytes_taken, phase_count);
    $display("Checked %0d results: %0d value bytes, found %0d, too_big %0d,",
             results_seen, value_bytes_seen, status_seen[ST_FOUND],
             status_seen[ST_TOO_BIG]);
    $display("  not_found %0d, malformed %0d.",
             status_seen[ST_NOT_FOUND], status_seen[ST_MALFORMED]);
    if (mismatch_count == 0) begin
      $display("** ber_tlv_tag_finder: PASSED **");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("** ber_tlv_tag_finder: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout: %0d results still owed, %0d bytes unsent",
             value_stream_q.size(), byte_feed_q.size());
    $display("** ber_tlv_tag_finder: FAILED **");
    $finish;
  end

endmodule
